### hdl/assert_macros.svh
// Assertion macros for the RTL of the seven-segment encoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/sdsse_pkg.sv
// Types, constants and the digit segment table of the signed decimal encoder.
// No dependencies.
package sdsse_pkg;

	localparam int ValueWidth = 16;
	localparam int SegWidth   = 7;
	localparam int PosCount   = 6;

	// Segment g only.
	localparam logic [SegWidth-1:0] MinusSeg = 7'h40;

	// Fixed-point reciprocals; each is exact over the magnitude range 0..32768.
	localparam logic [32:0] Recip10    = 33'd52429;   // >> 19
	localparam logic [32:0] Recip100   = 33'd83887;   // >> 23
	localparam logic [32:0] Recip1000  = 33'd67109;   // >> 26
	localparam logic [32:0] Recip10000 = 33'd107375;  // >> 30

	// Magnitude divided by 10^k, k = 0..4; widths cover 32768 / 10^k.
	typedef struct packed {
		logic        neg;
		logic [15:0] q0;
		logic [12:0] q1;
		logic [8:0]  q2;
		logic [5:0]  q3;
		logic [1:0]  q4;
	} quot_t;

	typedef logic [SegWidth-1:0] seg_t;

	function automatic seg_t digit_seg(input logic [3:0] digit);
		seg_t seg;
		case (digit)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7D;
			4'd7:    seg = 7'h07;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h6F;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

endpackage

### hdl/sdsse_quot.sv
// Magnitude and decimal quotients of a 16-bit signed value.
// Depends on sdsse_pkg (quot_t, reciprocal constants).
module sdsse_quot (
	input  logic [15:0]         value,
	output sdsse_pkg::quot_t    quot
);

	logic [15:0] mag;
	logic [32:0] p1, p2, p3, p4;

	// Two's complement negate; 0x8000 maps to 32768 as wanted.
	assign mag = value[15] ? (16'd0 - value) : value;

	assign p1 = 33'(mag) * sdsse_pkg::Recip10;
	assign p2 = 33'(mag) * sdsse_pkg::Recip100;
	assign p3 = 33'(mag) * sdsse_pkg::Recip1000;
	assign p4 = 33'(mag) * sdsse_pkg::Recip10000;

	always_comb begin
		quot.neg = value[15];
		quot.q0  = mag;
		quot.q1  = p1[31:19];
		quot.q2  = p2[31:23];
		quot.q3  = p3[31:26];
		quot.q4  = p4[31:30];
	end

endmodule

### hdl/sdsse_seg.sv
// Digit extraction, leading blank and sign placement for six positions.
// Depends on sdsse_pkg (quot_t, seg_t, digit_seg, MinusSeg).
module sdsse_seg (
	input  sdsse_pkg::quot_t  quot,
	output sdsse_pkg::seg_t   seg [sdsse_pkg::PosCount]
);

	logic [15:0] t0;
	logic [12:0] t1;
	logic [8:0]  t2;
	logic [5:0]  t3;
	logic [3:0]  dig [5];
	logic [4:0]  nz;

	// digit k = q_k - 10 * q_(k+1)
	assign t0 = quot.q0 - (16'(quot.q1) << 3) - (16'(quot.q1) << 1);
	assign t1 = quot.q1 - (13'(quot.q2) << 3) - (13'(quot.q2) << 1);
	assign t2 = quot.q2 - (9'(quot.q3) << 3) - (9'(quot.q3) << 1);
	assign t3 = quot.q3 - (6'(quot.q4) << 3) - (6'(quot.q4) << 1);

	assign dig[0] = t0[3:0];
	assign dig[1] = t1[3:0];
	assign dig[2] = t2[3:0];
	assign dig[3] = t3[3:0];
	assign dig[4] = {2'b00, quot.q4};

	// Position k is lit when the magnitude reaches 10^k; the leftmost never is.
	assign nz = {(quot.q4 != 2'd0), (quot.q3 != 6'd0), (quot.q2 != 9'd0),
		(quot.q1 != 13'd0), (quot.q0 != 16'd0)};

	always_comb begin
		// Rightmost position always shows a digit, zero included.
		seg[0] = sdsse_pkg::digit_seg(dig[0]);
		for (int k = 1; k < sdsse_pkg::PosCount - 1; k++) begin
			if (nz[k]) begin
				seg[k] = sdsse_pkg::digit_seg(dig[k]);
			end else if (quot.neg && nz[k-1]) begin
				seg[k] = sdsse_pkg::MinusSeg;
			end else begin
				seg[k] = '0;
			end
		end
		// Leftmost position: sign of a five-digit negative, else blank.
		if (quot.neg && nz[4]) begin
			seg[sdsse_pkg::PosCount-1] = sdsse_pkg::MinusSeg;
		end else begin
			seg[sdsse_pkg::PosCount-1] = '0;
		end
	end

endmodule

### hdl/signed_decimal_seven_segment_encode_top.sv
// Top level of the signed decimal seven-segment encoder: stream ports and pipeline.
// Depends on sdsse_pkg, sdsse_quot, sdsse_seg and assert_macros.svh.
//
// Usage:
//   Slave channel s_*: one 16-bit two's complement value per transfer.
//   Master channel m_*: six seven-segment patterns per transfer, rightmost
//   position in the lowest bits, bits 0..6 of each pattern are segments a..g.
//   Leading zeros are blank, zero shows a single 0, a negative value gets a
//   minus (segment g) just left of its top digit. Decimal points stay dark.
// Pipeline: a value accepted on s_* passes through the input register, the
//   quotient register and the output register before it is offered on
//   m_tvalid.
// Throughput: one transfer per cycle on both sides while m_tready is high;
//   quotient stage: four parallel constant multiplies; output stage: table lookup.
// Stall: each of the three registers holds while the one after it is full
//   and not draining; s_tready drops only when all three are full and
//   m_tready is low. Input keeps flowing while a result waits.
// Reset: arst_n clears all valid flags at once; no transfer is pending after.
module signed_decimal_seven_segment_encode_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata     // [6:0] digit0_segments, [13:7] digit1_segments,
	                                // [20:14] digit2_segments, [27:21] digit3_segments,
	                                // [34:28] digit4_segments, [41:35] digit5_segments,
	                                // [47:42] zero
);

	`include "assert_macros.svh"

	logic             valid_s1, valid_s2, out_valid_q;
	logic [15:0]      value_s1;
	sdsse_pkg::quot_t quot_c, quot_s2;
	sdsse_pkg::seg_t  seg_c [sdsse_pkg::PosCount];
	logic [41:0]      seg_q;
	logic             adv_out, ready_s2, ready_s1;

	// Each stage loads when it is empty or the one after it moves on.
	assign adv_out  = !out_valid_q || m_tready;
	assign ready_s2 = !valid_s2 || adv_out;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	sdsse_quot u_quot (
		.value (value_s1),
		.quot  (quot_c)
	);

	sdsse_seg u_seg (
		.quot (quot_s2),
		.seg  (seg_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (adv_out)  out_valid_q <= valid_s2;
		end
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) value_s1 <= s_tdata;
		if (ready_s2 && valid_s1) quot_s2 <= quot_c;
		if (adv_out && valid_s2) begin
			seg_q <= {seg_c[5], seg_c[4], seg_c[3], seg_c[2], seg_c[1], seg_c[0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, seg_q};

	// Input back-pressure only with the whole pipe full and stalled.
	`ASSERT_IMPL(a_ready_full, clk, arst_n, !s_tready, valid_s1 && valid_s2 && out_valid_q && !m_tready, "s_tready low with room in pipe")
	// A new result only comes from a filled quotient stage.
	`ASSERT_IMPL(a_out_from_s2, clk, arst_n, $rose(m_tvalid), $past(valid_s2), "result without quotient stage")
	// Rightmost position is never blank.
	`ASSERT_IMPL(a_digit0_lit, clk, arst_n, m_tvalid, m_tdata[6:0] != 7'd0, "digit0 blank")
	// Leftmost position holds only minus or blank.
	`ASSERT_IMPL(a_digit5_sign, clk, arst_n, m_tvalid, m_tdata[41:35] == 7'd0 || m_tdata[41:35] == sdsse_pkg::MinusSeg, "digit5 not sign or blank")

endmodule
